[hw/rtl/ocv_soc_recalibration_unit_assert.svh]
// ----------------------------------------------------------------------------
// ocv_soc_recalibration_unit_assert.svh
// Assertion macros used by the checker of the recalibration unit.
// ----------------------------------------------------------------------------
`ifndef OCV_SOC_RECALIBRATION_UNIT_ASSERT_SVH
`define OCV_SOC_RECALIBRATION_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define OCVR_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("ocvr check failed");

// next-cycle implication, sampled on clk, off during reset
`define OCVR_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("ocvr check failed");

`endif

[hw/rtl/ocvr_pkg.sv]
// ----------------------------------------------------------------------------
// ocvr_pkg
// Types, widths and the OCV table of the SOC recalibration unit.
// ----------------------------------------------------------------------------
package ocvr_pkg;

    localparam int TABLE_POINTS = 21;
    localparam int SEG_W        = $clog2(TABLE_POINTS);

    localparam int REST_W     = 32;
    localparam int VOLT_W     = 16;
    localparam int SOC_W      = 14;
    localparam int DEC_W      = 3;
    localparam int DRIFT_W    = 15;
    localparam int WEIGHT_W   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // interpolation divide: quotient = (num * RECIP) >> DIV_K, then one fixup
    localparam int NUM_W   = 31;
    localparam int DIV_K   = 31;
    localparam int RECIP_W = 32;
    localparam int ACC_W   = 25;

    localparam logic [SOC_W-1:0]    SOC_FULL   = 14'd10000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 11'd1024;
    localparam logic [ACC_W-1:0]    BLEND_HALF = 25'd512;

    localparam logic [REST_W-1:0]   REST_THRESHOLD_RST = 32'd600;
    localparam logic [WEIGHT_W-1:0] SAVED_WEIGHT_RST   = 11'd307;
    localparam logic [SOC_W-1:0]    DEFAULT_SOC_RST    = 14'd5000;

    typedef enum logic [DEC_W-1:0] {
        DEC_DEFAULT = 3'd0,
        DEC_OCV     = 3'd1,
        DEC_SAVED   = 3'd2,
        DEC_BLEND   = 3'd3,
        DEC_KEEP    = 3'd4
    } dec_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REST_THRESHOLD = 2'd0,
        CFG_SAVED_WEIGHT   = 2'd1,
        CFG_DEFAULT_SOC    = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OCV_ZERO   = 2'd0,
        OCV_FULL   = 2'd1,
        OCV_INTERP = 2'd2
    } ocv_mode_t;

    // rising table voltages, 0.1 mV
    localparam logic [VOLT_W-1:0] OCV_VOLT [TABLE_POINTS] = '{
        16'd33550, 16'd35010, 16'd35830, 16'd36200, 16'd36430, 16'd36600, 16'd36770,
        16'd36940, 16'd37120, 16'd37320, 16'd37550, 16'd37810, 16'd38120, 16'd38470,
        16'd38860, 16'd39290, 16'd39780, 16'd40330, 16'd40940, 16'd41560, 16'd41930
    };

    // evenly spaced SOC points, 0.01 percent
    localparam logic [SOC_W-1:0] SOC_GRID [TABLE_POINTS] = '{
        14'd0,    14'd500,  14'd1000, 14'd1500, 14'd2000, 14'd2500, 14'd3000,
        14'd3500, 14'd4000, 14'd4500, 14'd5000, 14'd5500, 14'd6000, 14'd6500,
        14'd7000, 14'd7500, 14'd8000, 14'd8500, 14'd9000, 14'd9500, 14'd10000
    };

    localparam logic [63:0] RECIP_ONE = 64'd1 << DIV_K;

    // floor(2^DIV_K / segment width), indexed by the upper point of the segment
    localparam logic [RECIP_W-1:0] RECIP [TABLE_POINTS] = '{
        32'd0,
        32'(RECIP_ONE / 64'(OCV_VOLT[1]  - OCV_VOLT[0])),
        32'(RECIP_ONE / 64'(OCV_VOLT[2]  - OCV_VOLT[1])),
        32'(RECIP_ONE / 64'(OCV_VOLT[3]  - OCV_VOLT[2])),
        32'(RECIP_ONE / 64'(OCV_VOLT[4]  - OCV_VOLT[3])),
        32'(RECIP_ONE / 64'(OCV_VOLT[5]  - OCV_VOLT[4])),
        32'(RECIP_ONE / 64'(OCV_VOLT[6]  - OCV_VOLT[5])),
        32'(RECIP_ONE / 64'(OCV_VOLT[7]  - OCV_VOLT[6])),
        32'(RECIP_ONE / 64'(OCV_VOLT[8]  - OCV_VOLT[7])),
        32'(RECIP_ONE / 64'(OCV_VOLT[9]  - OCV_VOLT[8])),
        32'(RECIP_ONE / 64'(OCV_VOLT[10] - OCV_VOLT[9])),
        32'(RECIP_ONE / 64'(OCV_VOLT[11] - OCV_VOLT[10])),
        32'(RECIP_ONE / 64'(OCV_VOLT[12] - OCV_VOLT[11])),
        32'(RECIP_ONE / 64'(OCV_VOLT[13] - OCV_VOLT[12])),
        32'(RECIP_ONE / 64'(OCV_VOLT[14] - OCV_VOLT[13])),
        32'(RECIP_ONE / 64'(OCV_VOLT[15] - OCV_VOLT[14])),
        32'(RECIP_ONE / 64'(OCV_VOLT[16] - OCV_VOLT[15])),
        32'(RECIP_ONE / 64'(OCV_VOLT[17] - OCV_VOLT[16])),
        32'(RECIP_ONE / 64'(OCV_VOLT[18] - OCV_VOLT[17])),
        32'(RECIP_ONE / 64'(OCV_VOLT[19] - OCV_VOLT[18])),
        32'(RECIP_ONE / 64'(OCV_VOLT[20] - OCV_VOLT[19]))
    };

endpackage

[hw/rtl/ocvr_if.sv]
// ----------------------------------------------------------------------------
// ocvr_if
// Valid/ready channels of the recalibration unit: key-on request, result.
// ----------------------------------------------------------------------------
interface ocvr_req_if;
    logic                          valid;
    logic                          ready;
    logic [ocvr_pkg::REST_W-1:0]   rest_time;
    logic                          have_voltage;
    logic [ocvr_pkg::VOLT_W-1:0]   cell_voltage;
    logic                          have_saved;
    logic [ocvr_pkg::SOC_W-1:0]    saved_soc;

    modport source (
        output valid, rest_time, have_voltage, cell_voltage, have_saved, saved_soc,
        input  ready
    );
    modport sink (
        input  valid, rest_time, have_voltage, cell_voltage, have_saved, saved_soc,
        output ready
    );
endinterface

interface ocvr_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [ocvr_pkg::SOC_W-1:0]         active_soc;
    logic [ocvr_pkg::DEC_W-1:0]         decision;
    logic [ocvr_pkg::SOC_W-1:0]         ocv_soc;
    logic signed [ocvr_pkg::DRIFT_W-1:0] drift;

    modport source (
        output valid, active_soc, decision, ocv_soc, drift,
        input  ready
    );
    modport sink (
        input  valid, active_soc, decision, ocv_soc, drift,
        output ready
    );
endinterface

[hw/rtl/ocv_soc_recalibration_unit.sv]
// ----------------------------------------------------------------------------
// ocv_soc_recalibration_unit
// Six register stages lie between request accept and result valid.
// Throughput: one request per cycle unless rsp.ready stalls the pipeline; the
//   multiply stages of the table divide and the blend are each fully pipelined.
// Reset: valid bits cleared, config registers back to 600 s / 307 / 5000.
// ----------------------------------------------------------------------------
module ocv_soc_recalibration_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    ocvr_req_if.sink                        req,
    ocvr_rsp_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [ocvr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ocvr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ocvr_pkg::*;

    // ---------------- configuration ----------------
    logic [REST_W-1:0]   rest_thr_reg;
    logic [WEIGHT_W-1:0] saved_weight_reg;
    logic [SOC_W-1:0]    default_soc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_thr_reg     <= REST_THRESHOLD_RST;
            saved_weight_reg <= SAVED_WEIGHT_RST;
            default_soc_reg  <= DEFAULT_SOC_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_REST_THRESHOLD: rest_thr_reg     <= cfg_wdata[REST_W-1:0];
                CFG_SAVED_WEIGHT:   saved_weight_reg <= cfg_wdata[WEIGHT_W-1:0];
                CFG_DEFAULT_SOC:    default_soc_reg  <= cfg_wdata[SOC_W-1:0];
                default:            ;
            endcase
        end
    end

    // ---------------- stage enables ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !out_valid_reg || rsp.ready;
    assign en5 = !s5_valid_reg || en6;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign req.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg  <= req.valid;
            if (en2) s2_valid_reg  <= s1_valid_reg;
            if (en3) s3_valid_reg  <= s2_valid_reg;
            if (en4) s4_valid_reg  <= s3_valid_reg;
            if (en5) s5_valid_reg  <= s4_valid_reg;
            if (en6) out_valid_reg <= s5_valid_reg;
        end
    end

    // ---------------- stage 1: segment search, decision ----------------
    logic [TABLE_POINTS-1:0] volt_gt;
    logic [SEG_W-1:0]        seg_next;
    ocv_mode_t               mode_next;
    dec_t                    dec_next;
    logic [SOC_W-1:0]        saved_next;

    always_comb
    begin
        for (int k = 0; k < TABLE_POINTS; k++)
            volt_gt[k] = req.cell_voltage > OCV_VOLT[k];

        // thermometer edge marks the first point at or above the voltage
        seg_next = '0;
        for (int k = 1; k < TABLE_POINTS; k++)
            if (volt_gt[k-1] && !volt_gt[k])
                seg_next = seg_next | SEG_W'(k);

        if (!req.have_voltage || !volt_gt[0])
            mode_next = OCV_ZERO;
        else if (volt_gt[TABLE_POINTS-1])
            mode_next = OCV_FULL;
        else
            mode_next = OCV_INTERP;

        saved_next = (req.saved_soc > SOC_FULL) ? SOC_FULL : req.saved_soc;

        if (!req.have_saved)
            dec_next = req.have_voltage ? DEC_OCV : DEC_DEFAULT;
        else if (req.rest_time < rest_thr_reg)
            dec_next = DEC_SAVED;
        else if (req.have_voltage)
            dec_next = DEC_BLEND;
        else
            dec_next = DEC_KEEP;
    end

    logic [SEG_W-1:0]  s1_seg_reg;
    ocv_mode_t         s1_mode_reg;
    dec_t              s1_dec_reg;
    logic [SOC_W-1:0]  s1_saved_reg;
    logic [VOLT_W-1:0] s1_volt_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_seg_reg   <= seg_next;
            s1_mode_reg  <= mode_next;
            s1_dec_reg   <= dec_next;
            s1_saved_reg <= saved_next;
            s1_volt_reg  <= req.cell_voltage;
        end
    end

    // ---------------- stage 2: numerator ----------------
    logic [SEG_W-1:0]  seg_lo;
    logic [VOLT_W-1:0] lo_volt;
    logic [VOLT_W-1:0] dv_next;
    logic [VOLT_W-1:0] dvolt;
    logic [SOC_W-1:0]  lo_soc_next;
    logic [SOC_W-1:0]  dsoc;
    logic [NUM_W-1:0]  num_next;

    always_comb
    begin
        seg_lo      = (s1_seg_reg == '0) ? '0 : s1_seg_reg - SEG_W'(1);
        lo_volt     = OCV_VOLT[seg_lo];
        dv_next     = OCV_VOLT[s1_seg_reg] - lo_volt;
        dvolt       = s1_volt_reg - lo_volt;
        lo_soc_next = SOC_GRID[seg_lo];
        dsoc        = SOC_GRID[s1_seg_reg] - lo_soc_next;
        // rounded half up: + dv/2 before the divide
        num_next    = NUM_W'(dvolt) * NUM_W'(dsoc) + NUM_W'(dv_next >> 1);
    end

    logic [SEG_W-1:0]  s2_seg_reg;
    ocv_mode_t         s2_mode_reg;
    dec_t              s2_dec_reg;
    logic [SOC_W-1:0]  s2_saved_reg;
    logic [NUM_W-1:0]  s2_num_reg;
    logic [VOLT_W-1:0] s2_dv_reg;
    logic [SOC_W-1:0]  s2_lo_soc_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_seg_reg    <= s1_seg_reg;
            s2_mode_reg   <= s1_mode_reg;
            s2_dec_reg    <= s1_dec_reg;
            s2_saved_reg  <= s1_saved_reg;
            s2_num_reg    <= num_next;
            s2_dv_reg     <= dv_next;
            s2_lo_soc_reg <= lo_soc_next;
        end
    end

    // ---------------- stage 3: reciprocal multiply ----------------
    logic [NUM_W+RECIP_W-1:0] recip_prod;
    logic [SOC_W-1:0]         q_est_next;

    always_comb
    begin
        recip_prod = (NUM_W+RECIP_W)'(s2_num_reg) * (NUM_W+RECIP_W)'(RECIP[s2_seg_reg]);
        // estimate is the true quotient or one below it
        q_est_next = recip_prod[DIV_K +: SOC_W];
    end

    ocv_mode_t         s3_mode_reg;
    dec_t              s3_dec_reg;
    logic [SOC_W-1:0]  s3_saved_reg;
    logic [NUM_W-1:0]  s3_num_reg;
    logic [VOLT_W-1:0] s3_dv_reg;
    logic [SOC_W-1:0]  s3_lo_soc_reg;
    logic [SOC_W-1:0]  s3_q_est_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_mode_reg   <= s2_mode_reg;
            s3_dec_reg    <= s2_dec_reg;
            s3_saved_reg  <= s2_saved_reg;
            s3_num_reg    <= s2_num_reg;
            s3_dv_reg     <= s2_dv_reg;
            s3_lo_soc_reg <= s2_lo_soc_reg;
            s3_q_est_reg  <= q_est_next;
        end
    end

    // ---------------- stage 4: back-multiply ----------------
    logic [NUM_W-1:0] back_next;

    assign back_next = NUM_W'(s3_q_est_reg) * NUM_W'(s3_dv_reg);

    ocv_mode_t         s4_mode_reg;
    dec_t              s4_dec_reg;
    logic [SOC_W-1:0]  s4_saved_reg;
    logic [NUM_W-1:0]  s4_num_reg;
    logic [VOLT_W-1:0] s4_dv_reg;
    logic [SOC_W-1:0]  s4_lo_soc_reg;
    logic [SOC_W-1:0]  s4_q_est_reg;
    logic [NUM_W-1:0]  s4_back_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_mode_reg   <= s3_mode_reg;
            s4_dec_reg    <= s3_dec_reg;
            s4_saved_reg  <= s3_saved_reg;
            s4_num_reg    <= s3_num_reg;
            s4_dv_reg     <= s3_dv_reg;
            s4_lo_soc_reg <= s3_lo_soc_reg;
            s4_q_est_reg  <= s3_q_est_reg;
            s4_back_reg   <= back_next;
        end
    end

    // ---------------- stage 5: quotient fixup, OCV SOC ----------------
    logic [NUM_W-1:0] rem;
    logic [SOC_W-1:0] quot;
    logic [SOC_W-1:0] ocv_next;

    always_comb
    begin
        rem  = s4_num_reg - s4_back_reg;
        quot = s4_q_est_reg + SOC_W'(rem >= NUM_W'(s4_dv_reg));
        case (s4_mode_reg)
            OCV_ZERO:   ocv_next = '0;
            OCV_FULL:   ocv_next = SOC_FULL;
            OCV_INTERP: ocv_next = s4_lo_soc_reg + quot;
            default:    ocv_next = '0;
        endcase
    end

    dec_t             s5_dec_reg;
    logic [SOC_W-1:0] s5_saved_reg;
    logic [SOC_W-1:0] s5_ocv_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_dec_reg   <= s4_dec_reg;
            s5_saved_reg <= s4_saved_reg;
            s5_ocv_reg   <= ocv_next;
        end
    end

    // ---------------- stage 6: blend, result register ----------------
    logic [WEIGHT_W-1:0]      weight;
    logic [ACC_W-1:0]         blend_acc;
    logic [SOC_W-1:0]         blend_soc;
    logic [SOC_W-1:0]         default_sat;
    logic [SOC_W-1:0]         active_next;
    logic signed [DRIFT_W-1:0] drift_next;

    always_comb
    begin
        weight      = (saved_weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : saved_weight_reg;
        blend_acc   = ACC_W'(weight) * ACC_W'(s5_saved_reg)
                    + ACC_W'(WEIGHT_ONE - weight) * ACC_W'(s5_ocv_reg)
                    + BLEND_HALF;
        blend_soc   = (blend_acc[ACC_W-1:10] > (ACC_W-10)'(SOC_FULL))
                    ? SOC_FULL : blend_acc[10 +: SOC_W];
        default_sat = (default_soc_reg > SOC_FULL) ? SOC_FULL : default_soc_reg;
        drift_next  = '0;

        case (s5_dec_reg)
            DEC_DEFAULT: active_next = default_sat;
            DEC_OCV:     active_next = s5_ocv_reg;
            DEC_SAVED:   active_next = s5_saved_reg;
            DEC_BLEND:
            begin
                active_next = blend_soc;
                drift_next  = $signed({1'b0, s5_saved_reg}) - $signed({1'b0, s5_ocv_reg});
            end
            DEC_KEEP:    active_next = s5_saved_reg;
            default:     active_next = s5_saved_reg;
        endcase
    end

    logic [SOC_W-1:0]          out_active_reg;
    dec_t                      out_dec_reg;
    logic [SOC_W-1:0]          out_ocv_reg;
    logic signed [DRIFT_W-1:0] out_drift_reg;

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            out_active_reg <= active_next;
            out_dec_reg    <= s5_dec_reg;
            out_ocv_reg    <= s5_ocv_reg;
            out_drift_reg  <= drift_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.active_soc = out_active_reg;
    assign rsp.decision   = out_dec_reg;
    assign rsp.ocv_soc    = out_ocv_reg;
    assign rsp.drift      = out_drift_reg;

endmodule

[hw/rtl/ocvr_checker.sv]
// ----------------------------------------------------------------------------
// ocvr_checker
// Port-level checks on the result channel of the recalibration unit.
// ----------------------------------------------------------------------------
`include "ocv_soc_recalibration_unit_assert.svh"

module ocvr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic [ocvr_pkg::SOC_W-1:0]        active_soc,
    input logic [ocvr_pkg::DEC_W-1:0]        decision,
    input logic [ocvr_pkg::SOC_W-1:0]        ocv_soc,
    input logic signed [ocvr_pkg::DRIFT_W-1:0] drift
);
    import ocvr_pkg::*;

    // drift is only reported for a blend
    `OCVR_ASSERT_IMP(a_drift_blend_only, rsp_valid && decision != DEC_BLEND, drift == '0)

    // default is only chosen when no voltage came in
    `OCVR_ASSERT_IMP(a_default_no_ocv, rsp_valid && decision == DEC_DEFAULT, ocv_soc == '0)

    `OCVR_ASSERT_IMP(a_ocv_only_active, rsp_valid && decision == DEC_OCV, active_soc == ocv_soc)

    `OCVR_ASSERT_IMP(a_soc_in_range, rsp_valid, active_soc <= SOC_FULL && ocv_soc <= SOC_FULL)

    `OCVR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(active_soc) && $stable(drift))

endmodule

bind ocv_soc_recalibration_unit ocvr_checker u_ocvr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .active_soc (rsp.active_soc),
    .decision   (rsp.decision),
    .ocv_soc    (rsp.ocv_soc),
    .drift      (rsp.drift)
);
